/* design/nlp_pkg.sv */
package nlp_pkg;

   localparam int DIGIT_BITS  = 4;
   localparam int MAX_DIGITS  = 10;
   localparam int RANK_BITS   = 22;
   localparam int DIGITS_BITS = DIGIT_BITS * MAX_DIGITS;
   localparam int STEP_BITS   = 4;
   localparam int STEP_COUNT  = 1 << STEP_BITS;

   typedef logic [STEP_BITS-1:0] step_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_WAIT,
      OP_CHECK,
      OP_WEIGHT,
      OP_DIV,
      OP_PICK,
      OP_BAD,
      OP_DONE
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      J_NEXT,
      J_ALWAYS,
      J_HOLD,
      J_IF_BAD,
      J_IF_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      logic [1:0] shift;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic start;
      logic range_bad;
      logic more_digits;
   } status_type;

   localparam step_type S_IDLE   = 4'd0;
   localparam step_type S_CHECK  = 4'd1;
   localparam step_type S_WEIGHT = 4'd2;
   localparam step_type S_DIV3   = 4'd3;
   localparam step_type S_DIV2   = 4'd4;
   localparam step_type S_DIV1   = 4'd5;
   localparam step_type S_DIV0   = 4'd6;
   localparam step_type S_PICK   = 4'd7;
   localparam step_type S_DONE   = 4'd8;
   localparam step_type S_BAD    = 4'd9;

   localparam ctrl_word_type UCODE [STEP_COUNT] = '{
      '{OP_WAIT,   2'd0, J_HOLD,    S_IDLE},
      '{OP_CHECK,  2'd0, J_IF_BAD,  S_BAD},
      '{OP_WEIGHT, 2'd0, J_NEXT,    S_IDLE},
      '{OP_DIV,    2'd3, J_NEXT,    S_IDLE},
      '{OP_DIV,    2'd2, J_NEXT,    S_IDLE},
      '{OP_DIV,    2'd1, J_NEXT,    S_IDLE},
      '{OP_DIV,    2'd0, J_NEXT,    S_IDLE},
      '{OP_PICK,   2'd0, J_IF_MORE, S_WEIGHT},
      '{OP_DONE,   2'd0, J_ALWAYS,  S_IDLE},
      '{OP_BAD,    2'd0, J_ALWAYS,  S_DONE},
      '{OP_WAIT,   2'd0, J_ALWAYS,  S_IDLE},
      '{OP_WAIT,   2'd0, J_ALWAYS,  S_IDLE},
      '{OP_WAIT,   2'd0, J_ALWAYS,  S_IDLE},
      '{OP_WAIT,   2'd0, J_ALWAYS,  S_IDLE},
      '{OP_WAIT,   2'd0, J_ALWAYS,  S_IDLE},
      '{OP_WAIT,   2'd0, J_ALWAYS,  S_IDLE}
   };

   localparam logic [RANK_BITS-1:0] FACT_TABLE [16] = '{
      22'd1, 22'd1, 22'd2, 22'd6, 22'd24, 22'd120, 22'd720, 22'd5040,
      22'd40320, 22'd362880, 22'd3628800, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
   };

   function automatic logic [DIGITS_BITS-1:0] descending(input int count);
      logic [DIGITS_BITS-1:0] packed_val;
      packed_val = '0;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (k < count) begin
            packed_val[k*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'(k);
         end
      end
      return packed_val;
   endfunction

endpackage

/* design/nth_lexicographic_permutation_core.sv */
// Sequence: a range check after accept, then per digit the steps below, then a done
// step that raises the strobe; a rank past the permutation count skips the digits for a bad step.
// Throughput: one item at a time; busy drops in the strobe cycle, so a new
// start can be taken at that edge. Each digit costs one weight load, four
// restoring compare-subtract steps and one pick from the digit pool.
// Reset (synchronous) returns the sequencer to idle and clears the strobe.
module nth_lexicographic_permutation_core
   import nlp_pkg::*;
#(
   parameter int DIGIT_COUNT = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [RANK_BITS-1:0]   req_rank,
   output logic                   rsp_valid,
   output logic [DIGITS_BITS-1:0] rsp_digits,
   output logic                   rsp_found
);

   // digit count limited to 1..MAX_DIGITS
   localparam int USED_DIGITS = (DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS :
                                ((DIGIT_COUNT < 1) ? 1 : DIGIT_COUNT);
   localparam int POOL_BITS = (USED_DIGITS > 1) ? $clog2(USED_DIGITS) : 1;
   localparam logic [3:0] LAST_POS = 4'(USED_DIGITS - 1);
   localparam logic [RANK_BITS-1:0] FACT_D = FACT_TABLE[USED_DIGITS];
   localparam logic [DIGITS_BITS-1:0] DESC_DIGITS = descending(USED_DIGITS);

   ctrl_word_type ctrl;
   status_type    status;
   logic          accept;

   logic [RANK_BITS-1:0]   rem_ff, rem_in;
   logic [RANK_BITS-1:0]   weight_ff, weight_in;
   logic [3:0]             quot_ff, quot_in;
   logic [3:0]             pos_ff, pos_in;
   logic [DIGITS_BITS-1:0] packed_ff, packed_in;
   logic                   found_ff, found_in;
   logic                   valid_ff, valid_in;
   logic [DIGIT_BITS-1:0]  pool_ff [USED_DIGITS];
   logic [DIGIT_BITS-1:0]  pool_in [USED_DIGITS];

   logic [RANK_BITS+2:0]   trial;
   logic [DIGIT_BITS-1:0]  picked;

   nlp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   assign accept             = start && !busy;
   assign status.start       = start;
   assign status.range_bad   = (rem_ff >= FACT_D);
   assign status.more_digits = (pos_ff != LAST_POS);

   assign trial  = {3'b000, weight_ff} << ctrl.shift;
   assign picked = pool_ff[quot_ff[POOL_BITS-1:0]];

   always_comb begin
      rem_in    = rem_ff;
      weight_in = weight_ff;
      quot_in   = quot_ff;
      pos_in    = pos_ff;
      packed_in = packed_ff;
      found_in  = found_ff;
      valid_in  = 1'b0;
      for (int k = 0; k < USED_DIGITS; k++) begin
         pool_in[k] = pool_ff[k];
      end
      case (ctrl.op)
         OP_WAIT: begin
            if (accept) begin
               rem_in    = (req_rank == '0) ? '0 : req_rank - 22'd1;
               pos_in    = '0;
               packed_in = '0;
               found_in  = 1'b1;
               for (int k = 0; k < USED_DIGITS; k++) begin
                  pool_in[k] = DIGIT_BITS'(k);
               end
            end
         end
         OP_CHECK: begin
            if (status.range_bad) begin
               found_in = 1'b0;
            end
         end
         OP_WEIGHT: begin
            weight_in = FACT_TABLE[LAST_POS - pos_ff];
            quot_in   = '0;
         end
         OP_DIV: begin
            if ({3'b000, rem_ff} >= trial) begin
               rem_in                = rem_ff - trial[RANK_BITS-1:0];
               quot_in[ctrl.shift]   = 1'b1;
            end
         end
         OP_PICK: begin
            packed_in = {packed_ff[DIGITS_BITS-DIGIT_BITS-1:0], picked};
            pos_in    = pos_ff + 4'd1;
            // close the gap left by the picked digit
            for (int k = 0; k < USED_DIGITS - 1; k++) begin
               if (4'(k) >= quot_ff) begin
                  pool_in[k] = pool_ff[k+1];
               end
            end
         end
         OP_BAD: begin
            packed_in = DESC_DIGITS;
         end
         OP_DONE: begin
            valid_in = 1'b1;
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      weight_ff <= weight_in;
      quot_ff   <= quot_in;
      pos_ff    <= pos_in;
      packed_ff <= packed_in;
      found_ff  <= found_in;
      for (int k = 0; k < USED_DIGITS; k++) begin
         pool_ff[k] <= pool_in[k];
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_digits = packed_ff;
   assign rsp_found  = found_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("sequencer did not leave idle after accept");

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat shown while busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat longer than one cycle");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (busy && ctrl.op == OP_PICK) |-> (pos_ff <= LAST_POS))
      else $error("digit position past last digit");

endmodule

/* design/nlp_sequencer.sv */
module nlp_sequencer
   import nlp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  status_type    status,
   output ctrl_word_type ctrl,
   output logic          busy
);

   step_type step_ff;
   step_type step_in;
   step_type step_inc;

   assign ctrl     = UCODE[step_ff];
   assign busy     = (step_ff != S_IDLE);
   assign step_inc = step_ff + 4'd1;

   always_comb begin
      case (ctrl.cond)
         J_NEXT:    step_in = step_inc;
         J_ALWAYS:  step_in = ctrl.target;
         J_HOLD:    step_in = status.start ? step_inc : ctrl.target;
         J_IF_BAD:  step_in = status.range_bad ? ctrl.target : step_inc;
         J_IF_MORE: step_in = status.more_digits ? ctrl.target : step_inc;
         default:   step_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* tb/tb_nth_lexicographic_permutation_core.sv */
module tb_nth_lexicographic_permutation_core
   import nlp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIGIT_COUNT = 10;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_RANKS = 600;
   localparam int PERM_COUNT = 3628800;

   class perm_scoreboard;
      logic [DIGITS_BITS-1:0] digits_q[$];
      logic found_q[$];
      int errors;
      int width;

      function new(int digit_count);
         width = digit_count;
         if (width > MAX_DIGITS) width = MAX_DIGITS;
         if (width < 1) width = 1;
         errors = 0;
      endfunction

      function longint factorial_of(int k);
         longint f;
         f = 1;
         for (int i = 2; i <= k; i++) f = f * i;
         return f;
      endfunction

      function void permutation_of_rank(input logic [RANK_BITS-1:0] rank,
                                        output logic [DIGITS_BITS-1:0] digits,
                                        output logic found);
         longint rem;
         longint w;
         int pool[MAX_DIGITS];
         int left;
         int idx;
         rem = (rank == '0) ? 0 : longint'(rank) - 1;
         left = width;
         digits = '0;
         for (int k = 0; k < MAX_DIGITS; k++) pool[k] = k;
         if (rem >= factorial_of(width)) begin
            found = 1'b0;
            for (int k = 0; k < width; k++) begin
               digits = {digits[DIGITS_BITS-DIGIT_BITS-1:0], DIGIT_BITS'(width - 1 - k)};
            end
         end else begin
            found = 1'b1;
            for (int pos = 0; pos < width; pos++) begin
               w = factorial_of(width - 1 - pos);
               idx = int'(rem / w);
               rem = rem % w;
               if (idx >= left) idx = left - 1;
               digits = {digits[DIGITS_BITS-DIGIT_BITS-1:0], DIGIT_BITS'(pool[idx])};
               for (int k = idx; k + 1 < left; k++) pool[k] = pool[k + 1];
               left--;
            end
         end
      endfunction

      task report(input string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      function void note_rank(input logic [RANK_BITS-1:0] rank);
         logic [DIGITS_BITS-1:0] digits;
         logic found;
         permutation_of_rank(rank, digits, found);
         digits_q = {digits_q, digits};
         found_q = {found_q, found};
      endfunction

      task check_result(input logic [DIGITS_BITS-1:0] digits, input logic found);
         logic [DIGITS_BITS-1:0] want_digits;
         logic want_found;
         if (digits_q.size() == 0) begin
            report($sformatf("unexpected result digits=%h found=%b", digits, found));
         end else begin
            want_digits = digits_q.pop_front();
            want_found = found_q.pop_front();
            if (digits !== want_digits) begin
               report($sformatf("digits %h, want %h", digits, want_digits));
            end
            if (found !== want_found) begin
               report($sformatf("found %b, want %b", found, want_found));
            end
         end
      endtask

      function int pending();
         return digits_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [RANK_BITS-1:0] req_rank;
   logic rsp_valid;
   logic [DIGITS_BITS-1:0] rsp_digits;
   logic rsp_found;
   int stall_count = 0;

   perm_scoreboard sb = new(DIGIT_COUNT);

   nth_lexicographic_permutation_core #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_rank(req_rank),
      .rsp_valid(rsp_valid),
      .rsp_digits(rsp_digits),
      .rsp_found(rsp_found)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_result(rsp_digits, rsp_found);
      end
   end

   // stall watchdog: counts cycles with neither a request nor a result beat
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("tb_nth_lexicographic_permutation_core: errors");
            $finish;
         end
      end
   end

   task idle_for(input int cycles);
      for (int i = 0; i < cycles; i++) begin
         start <= 1'b0;
         req_rank <= RANK_BITS'($urandom);
         @(posedge clock);
      end
   endtask

   task send_rank(input logic [RANK_BITS-1:0] rank);
      start <= 1'b1;
      req_rank <= rank;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_rank(rank);
   endtask

   function logic [RANK_BITS-1:0] random_rank();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return RANK_BITS'($urandom_range(1, PERM_COUNT));
      if (pick < 90) return RANK_BITS'($urandom_range(PERM_COUNT + 1, (1 << RANK_BITS) - 1));
      if (pick < 95) return RANK_BITS'($urandom_range(0, 30));
      return RANK_BITS'($urandom);
   endfunction

   initial begin
      logic [RANK_BITS-1:0] edge_ranks[$];
      edge_ranks = '{22'd0, 22'd1, 22'd2, 22'd3, 22'd24, 22'd25, 22'd120, 22'd121,
                     22'd720, 22'd5040, 22'd40320, 22'd40321, 22'd362880, 22'd362881,
                     22'd1814400, 22'd1814401, 22'd2097151, 22'd2097152, 22'd1234567,
                     22'd3628799, 22'd3628800, 22'd3628801, 22'd3628802, 22'h3FFFFF};
      reset <= 1'b1;
      start <= 1'b0;
      req_rank <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (edge_ranks[i]) begin
         if (i % 3 == 1) idle_for($urandom_range(1, 5));
         send_rank(edge_ranks[i]);
      end

      for (int n = 0; n < RANDOM_RANKS; n++) begin
         // a long run back to back, occasional random gaps elsewhere
         if ((n < 250 || n >= 400) && $urandom_range(0, 99) < 15) begin
            idle_for($urandom_range(1, 70));
         end
         send_rank(random_rank());
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb_nth_lexicographic_permutation_core: clean");
      end else begin
         $display("tb_nth_lexicographic_permutation_core: errors");
      end
      $finish;
   end

endmodule
